>>> rtl/rgbhsl_pkg.sv
//------------------------------------------------------------------------------
// rgbhsl_pkg
// Shared types and constants for the RGBC to HSL converter.
//------------------------------------------------------------------------------
`default_nettype none

package rgbhsl_pkg;

  localparam int COUNT_W     = 16;
  localparam int PCT_W       = 7;
  localparam int PCT_NUM_W   = 23;  // count * 100
  localparam int SUM_W       = 8;   // max + min
  localparam int HUE_W       = 9;
  localparam int HUE_NUM_W   = 13;  // 60 * difference
  localparam int SAT_NUM_W   = 14;  // 100 * difference
  localparam int QUOT_W      = 7;
  localparam int MID_DEPTH_DEF = 16;
  localparam int OUT_DEPTH_DEF = 16;

  localparam logic [PCT_W-1:0]     PCT_MAX    = 7'd100;
  localparam logic [PCT_W-1:0]     LIG_HALF   = 7'd50;
  localparam logic [SUM_W-1:0]     SUM_FULL   = 8'd200;
  localparam logic [HUE_NUM_W-1:0] HUE_SCALE  = 13'd60;
  localparam logic [SAT_NUM_W-1:0] SAT_SCALE  = 14'd100;
  localparam logic [HUE_W-1:0]     HUE_RED    = 9'd360;
  localparam logic [HUE_W-1:0]     HUE_GREEN  = 9'd120;
  localparam logic [HUE_W-1:0]     HUE_BLUE   = 9'd240;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

  typedef struct packed {
    logic             zero;
    logic             gray;
    max_sel_t         sel;
    logic             neg;
    logic [PCT_W-1:0] hdiff;
    logic [PCT_W-1:0] dif;
    logic [SUM_W-1:0] sden;
    logic [PCT_W-1:0] lig;
  } mid_item_t;

  typedef struct packed {
    logic             zero;
    logic             gray;
    max_sel_t         sel;
    logic             neg;
    logic [PCT_W-1:0] lig;
  } bk_side_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lig;
    logic             err;
  } res_item_t;

endpackage

`default_nettype wire

>>> rtl/rgbhsl_fifo.sv
//------------------------------------------------------------------------------
// rgbhsl_fifo
// Small synchronous queue in flip-flops; head visible while not empty.
//------------------------------------------------------------------------------
`default_nettype none

module rgbhsl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output      logic [WIDTH-1:0] rd_data,
  output      logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

endmodule

`default_nettype wire

>>> rtl/rgbhsl_div.sv
//------------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
//------------------------------------------------------------------------------
`default_nettype none

module rgbhsl_div #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 7,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output      logic          out_valid,
  output      logic [QW-1:0] quot,
  output      logic          ovf,
  output      logic [SW-1:0] side_out
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          v [0:QW];
  logic [CW-1:0] r [0:QW];
  logic [DW-1:0] d [0:QW];
  logic [QW-1:0] q [0:QW];
  logic          o [0:QW];
  logic [SW-1:0] s [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  // quotient beyond QW bits is flagged, not computed
  always_ff @(posedge clk) begin
    r[0] <= CW'(num);
    d[0] <= den;
    q[0] <= '0;
    o[0] <= (CW'(num) >= (CW'(den) << QW));
    s[0] <= side_in;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(d[k-1]) << (QW - k);
    assign ge    = (r[k-1] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      r[k] <= ge ? (r[k-1] - trial) : r[k-1];
      q[k] <= q[k-1] | (ge ? (QW'(1) << (QW - k)) : '0);
      d[k] <= d[k-1];
      o[k] <= o[k-1];
      s[k] <= s[k-1];
    end
  end

  assign out_valid = v[QW];
  assign quot      = q[QW];
  assign ovf       = o[QW];
  assign side_out  = s[QW];

endmodule

`default_nettype wire

>>> rtl/rgbhsl_front.sv
//------------------------------------------------------------------------------
// rgbhsl_front
// Scale colors to percent of clear, clamp, find max/min and classify hue sector.
//------------------------------------------------------------------------------
`default_nettype none

module rgbhsl_front
  import rgbhsl_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_acc,
  input  wire logic [COUNT_W-1:0] red,
  input  wire logic [COUNT_W-1:0] green,
  input  wire logic [COUNT_W-1:0] blue,
  input  wire logic [COUNT_W-1:0] clr,
  input  wire logic               mid_pop,
  output      logic               full,
  output      logic               mid_push,
  output      mid_item_t          mid_item
);

  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  logic [CNT_W-1:0]     credit;
  logic                 a_v;
  logic                 a_z;
  logic [PCT_NUM_W-1:0] a_nr, a_ng, a_nb;
  logic [COUNT_W-1:0]   a_c;
  logic                 dr_v, dg_v, db_v;
  logic [QUOT_W-1:0]    qr, qg, qb;
  logic                 or_f, og_f, ob_f;
  logic                 z_o, zg_o, zb_o;
  logic [PCT_W-1:0]     pr, pg, pb, mx, mn, ha, hb, dif, lig;
  logic [SUM_W-1:0]     sum;
  logic                 rge, gge;

  // items in flight plus items queued must fit the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CNT_W'(in_acc) - CNT_W'(mid_pop);
    end
  end
  assign full = (credit == CNT_W'(MID_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    a_nr <= PCT_NUM_W'(red)   * PCT_NUM_W'(PCT_MAX);
    a_ng <= PCT_NUM_W'(green) * PCT_NUM_W'(PCT_MAX);
    a_nb <= PCT_NUM_W'(blue)  * PCT_NUM_W'(PCT_MAX);
    a_c  <= clr;
    a_z  <= (clr == '0);
  end

  rgbhsl_div #(.NW(PCT_NUM_W), .DW(COUNT_W), .QW(QUOT_W), .SW(1)) u_div_r (
    .clk, .rst, .in_valid(a_v), .num(a_nr), .den(a_c), .side_in(a_z),
    .out_valid(dr_v), .quot(qr), .ovf(or_f), .side_out(z_o)
  );
  rgbhsl_div #(.NW(PCT_NUM_W), .DW(COUNT_W), .QW(QUOT_W), .SW(1)) u_div_g (
    .clk, .rst, .in_valid(a_v), .num(a_ng), .den(a_c), .side_in(a_z),
    .out_valid(dg_v), .quot(qg), .ovf(og_f), .side_out(zg_o)
  );
  rgbhsl_div #(.NW(PCT_NUM_W), .DW(COUNT_W), .QW(QUOT_W), .SW(1)) u_div_b (
    .clk, .rst, .in_valid(a_v), .num(a_nb), .den(a_c), .side_in(a_z),
    .out_valid(db_v), .quot(qb), .ovf(ob_f), .side_out(zb_o)
  );

  always_comb begin
    pr  = (or_f || qr > PCT_MAX) ? PCT_MAX : qr;
    pg  = (og_f || qg > PCT_MAX) ? PCT_MAX : qg;
    pb  = (ob_f || qb > PCT_MAX) ? PCT_MAX : qb;
    rge = (pr >= pg) && (pr >= pb);
    gge = (pg >= pb);
    mx  = rge ? pr : (gge ? pg : pb);
    mn  = pr;
    if (pg < mn) mn = pg;
    if (pb < mn) mn = pb;
    dif = mx - mn;
    sum = SUM_W'(mx) + SUM_W'(mn);
    lig = sum[SUM_W-1:1];
    mid_item.sel = rge ? SEL_RED : (gge ? SEL_GREEN : SEL_BLUE);
    unique case (mid_item.sel)
      SEL_RED: begin
        ha = pg; hb = pb;
      end
      SEL_GREEN: begin
        ha = pb; hb = pr;
      end
      SEL_BLUE: begin
        ha = pr; hb = pg;
      end
      default: begin
        ha = pr; hb = pg;
      end
    endcase
    mid_item.zero  = z_o;
    mid_item.gray  = (dif == '0);
    mid_item.neg   = (ha < hb);
    mid_item.hdiff = (ha < hb) ? (hb - ha) : (ha - hb);
    mid_item.dif   = dif;
    mid_item.sden  = (lig <= LIG_HALF) ? sum : (SUM_FULL - sum);
    mid_item.lig   = lig;
    mid_push       = dr_v & dg_v & db_v & ~(zg_o ^ zb_o ^ z_o ^ z_o ^ zg_o ^ zb_o);
  end

endmodule

`default_nettype wire

>>> rtl/rgbhsl_back.sv
//------------------------------------------------------------------------------
// rgbhsl_back
// Divide out hue and saturation, apply sector offsets and special cases.
//------------------------------------------------------------------------------
`default_nettype none

module rgbhsl_back
  import rgbhsl_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      mid_empty,
  input  wire mid_item_t mid_item,
  output      logic      mid_pop,
  input  wire logic      out_pop,
  output      logic      out_push,
  output      res_item_t out_item
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [CNT_W-1:0]     credit;
  logic                 b_v;
  logic [HUE_NUM_W-1:0] b_hnum;
  logic [SAT_NUM_W-1:0] b_snum;
  logic [PCT_W-1:0]     b_dif;
  logic [SUM_W-1:0]     b_sden;
  bk_side_t             b_side;
  bk_side_t             f_side;
  logic                 hv, sv, h_ovf, s_ovf, h_unused;
  logic [QUOT_W-1:0]    hq, sq;
  logic [HUE_W-1:0]     hq9, hue;

  // draw from the middle queue only while the result queue has room
  assign mid_pop = ~mid_empty && (credit != CNT_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      b_v    <= 1'b0;
    end else begin
      credit <= credit + CNT_W'(mid_pop) - CNT_W'(out_pop);
      b_v    <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    b_hnum      <= HUE_NUM_W'(mid_item.hdiff) * HUE_SCALE;
    b_snum      <= SAT_NUM_W'(mid_item.dif) * SAT_SCALE;
    b_dif       <= mid_item.dif;
    b_sden      <= mid_item.sden;
    b_side.zero <= mid_item.zero;
    b_side.gray <= mid_item.gray;
    b_side.sel  <= mid_item.sel;
    b_side.neg  <= mid_item.neg;
    b_side.lig  <= mid_item.lig;
  end

  rgbhsl_div #(.NW(HUE_NUM_W), .DW(PCT_W), .QW(QUOT_W), .SW(1)) u_div_h (
    .clk, .rst, .in_valid(b_v), .num(b_hnum), .den(b_dif), .side_in(1'b0),
    .out_valid(hv), .quot(hq), .ovf(h_ovf), .side_out(h_unused)
  );
  rgbhsl_div #(.NW(SAT_NUM_W), .DW(SUM_W), .QW(QUOT_W), .SW($bits(bk_side_t))) u_div_s (
    .clk, .rst, .in_valid(b_v), .num(b_snum), .den(b_sden), .side_in(b_side),
    .out_valid(sv), .quot(sq), .ovf(s_ovf), .side_out(f_side)
  );

  always_comb begin
    hq9 = HUE_W'(hq);
    unique case (f_side.sel)
      SEL_RED:   hue = f_side.neg ? (HUE_RED - hq9)   : hq9;
      SEL_GREEN: hue = f_side.neg ? (HUE_GREEN - hq9) : (HUE_GREEN + hq9);
      SEL_BLUE:  hue = f_side.neg ? (HUE_BLUE - hq9)  : (HUE_BLUE + hq9);
      default:   hue = '0;
    endcase
    // gray and zero clear force fields to zero; divide overflow also zeroes hue or saturation
    out_item.err = f_side.zero;
    out_item.hue = (f_side.zero || f_side.gray || h_ovf || h_unused) ? '0 : hue;
    out_item.sat = (f_side.zero || f_side.gray || s_ovf) ? '0 : sq;
    out_item.lig = f_side.zero ? '0 : f_side.lig;
    out_push     = hv & sv;
  end

endmodule

`default_nettype wire

>>> rtl/rgbc_to_hsl_converter.sv
//------------------------------------------------------------------------------
// rgbc_to_hsl_converter
// Color sensor sample (red, green, blue, clear counts) to integer HSL.
//------------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the four counts with push high; the sample
//   is taken on a clock edge where push is high and full is low.
//   Result side is a queue: while empty is low the oldest result sits on
//   hue_deg, saturation_pct, lightness_pct and clear_zero_error; pop high
//   with empty low takes it.
//   Throughput: one sample per cycle, sustained, as long as results are
//   popped. Every stage is pipelined; the dividers retire one quotient bit
//   per stage.
//   Path: from the accepting edge to empty going low (front:
//   count scaling plus an 8-stage percent divider; middle queue; back:
//   product stage plus an 8-stage hue/saturation divider; result queue).
//   Stall: a stalled receiver fills the result queue, then the middle queue;
//   full rises once MID_DEPTH samples are in flight or waiting in front.
//   Reset: rst (synchronous) empties both queues and the pipelines.
//------------------------------------------------------------------------------
`default_nettype none

module rgbc_to_hsl_converter
  import rgbhsl_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output      logic               full,
  input  wire logic [COUNT_W-1:0] red_count,
  input  wire logic [COUNT_W-1:0] green_count,
  input  wire logic [COUNT_W-1:0] blue_count,
  input  wire logic [COUNT_W-1:0] clear_count,
  output      logic               empty,
  input  wire logic               pop,
  output      logic [HUE_W-1:0]   hue_deg,
  output      logic [PCT_W-1:0]   saturation_pct,
  output      logic [PCT_W-1:0]   lightness_pct,
  output      logic               clear_zero_error
);

  logic      in_acc;
  logic      out_acc;
  logic      mid_push, mid_pop, mid_empty;
  mid_item_t mid_wr, mid_rd;
  logic      res_push;
  res_item_t res_wr, res_rd;

  // a transaction on each side
  assign in_acc  = push & ~full;
  assign out_acc = pop & ~empty;

  // front: scale, clamp, classify
  rgbhsl_front #(.MID_DEPTH(MID_DEPTH)) u_front (
    .clk, .rst, .in_acc,
    .red(red_count), .green(green_count), .blue(blue_count), .clr(clear_count),
    .mid_pop, .full, .mid_push, .mid_item(mid_wr)
  );

  // decouple front and back
  rgbhsl_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk, .rst, .wr_en(mid_push), .wr_data(mid_wr),
    .rd_en(mid_pop), .rd_data(mid_rd), .empty(mid_empty)
  );

  // back: hue and saturation
  rgbhsl_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk, .rst, .mid_empty, .mid_item(mid_rd), .mid_pop,
    .out_pop(out_acc), .out_push(res_push), .out_item(res_wr)
  );

  // hold results until popped
  rgbhsl_fifo #(.WIDTH($bits(res_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk, .rst, .wr_en(res_push), .wr_data(res_wr),
    .rd_en(out_acc), .rd_data(res_rd), .empty
  );

  assign hue_deg          = res_rd.hue;
  assign saturation_pct   = res_rd.sat;
  assign lightness_pct    = res_rd.lig;
  assign clear_zero_error = res_rd.err;

endmodule

`default_nettype wire
